[rtl/polygon_fan_triangulator_macros.svh]
// Assertion macros shared by the polygon fan triangulator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef POLYGON_FAN_TRIANGULATOR_MACROS_SVH
`define POLYGON_FAN_TRIANGULATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFT_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("pft assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define PFT_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("pft assertion failed: next-cycle check");

`endif

[rtl/pft_pkg.sv]
// Types and constants for the polygon fan triangulator.
// Depends on nothing; used by the channel interfaces and the top level.
package pft_pkg;

   localparam int INDEX_BITS = 24;
   localparam int FIELD_BITS = 24;
   localparam int RAW_BITS   = FIELD_BITS + 1;

   typedef enum logic [1:0] {
      HELD_NONE,
      HELD_ONE,
      HELD_TWO
   } held_type;

   typedef enum logic [1:0] {
      SLOT_A,
      SLOT_B,
      SLOT_C
   } slot_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] corner_ordinal;
      logic [FIELD_BITS-1:0] point_index;
   } vertex_type;

endpackage

[rtl/pft_req_if.sv]
// Input channel of the polygon fan triangulator: one polygon corner per transfer.
// Depends on pft_pkg.
interface pft_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [pft_pkg::RAW_BITS-1:0] vertex_index;
   logic                                mesh_start;

   modport source (output valid, output vertex_index, output mesh_start, input ready);
   modport sink (input valid, input vertex_index, input mesh_start, output ready);
endinterface

[rtl/pft_rsp_if.sv]
// Result channel of the polygon fan triangulator: one triangle vertex per transfer.
// Depends on pft_pkg.
interface pft_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pft_pkg::FIELD_BITS-1:0]  corner_ordinal;
   logic [pft_pkg::FIELD_BITS-1:0]  point_index;
   logic                            triangle_end;

   modport source (output valid, output corner_ordinal, output point_index,
                   output triangle_end, input ready);
   modport sink (input valid, input corner_ordinal, input point_index,
                 input triangle_end, output ready);
endinterface

[rtl/polygon_fan_triangulator.sv]
// Polygon fan triangulator top level: corner tracking and triangle output buffer.
// Depends on pft_pkg, pft_req_if, pft_rsp_if and polygon_fan_triangulator_macros.svh.
//
//   channel   direction  transfer carries
//   req_bus   in         vertex_index, mesh_start
//   rsp_bus   out        corner_ordinal, point_index, triangle_end
//   csr_*     in         clockwise_winding
//
// A corner is handled in the cycle of its transfer; a triangle goes into a three-entry
// output buffer and leaves it one vertex per cycle while rsp_bus is ready.
// A corner that completes a triangle can enter the buffer as its last vertex is taken.
// A corner that emits nothing is taken every cycle while the buffer is free.
// The input stalls while the buffer holds a vertex other than the last one being taken.
// Synchronous reset clears the corner state, the counter, the winding bit and the buffer.
`include "polygon_fan_triangulator_macros.svh"

module polygon_fan_triangulator (
   input  logic          clock,
   input  logic          reset,
   pft_req_if.sink       req_bus,
   pft_rsp_if.source     rsp_bus,
   input  logic          csr_write_enable,
   input  logic          csr_write_data
);

   logic                              winding_ff;
   logic [pft_pkg::INDEX_BITS-1:0]    counter_ff;
   logic [pft_pkg::INDEX_BITS-1:0]    counter_eff;
   pft_pkg::held_type                 held_ff, held_in, held_eff;
   pft_pkg::vertex_type               first_ff, first_in;
   pft_pkg::vertex_type               prev_ff, prev_in;
   pft_pkg::vertex_type               cur;
   pft_pkg::vertex_type               buf_ff [3];
   pft_pkg::slot_type                 slot_ff, slot_in;
   logic                              buf_valid_ff, buf_valid_in;
   logic                              closing;
   logic                              emit;
   logic                              req_fire;
   logic                              rsp_fire;
   logic                              last_taken;

   always_comb begin
      closing     = req_bus.vertex_index[pft_pkg::RAW_BITS-1];
      counter_eff = req_bus.mesh_start ? '0 : counter_ff;
      held_eff    = req_bus.mesh_start ? pft_pkg::HELD_NONE : held_ff;
      cur.corner_ordinal = pft_pkg::FIELD_BITS'(counter_eff);
      cur.point_index    = closing ? ~req_bus.vertex_index[pft_pkg::FIELD_BITS-1:0]
                                   : req_bus.vertex_index[pft_pkg::FIELD_BITS-1:0];
      emit = (held_eff == pft_pkg::HELD_TWO);
   end

   assign rsp_fire   = rsp_bus.valid && rsp_bus.ready;
   assign last_taken = rsp_fire && (slot_ff == pft_pkg::SLOT_C);
   assign req_bus.ready = !buf_valid_ff || last_taken;
   assign req_fire   = req_bus.valid && req_bus.ready;

   always_comb begin
      held_in  = held_ff;
      first_in = first_ff;
      prev_in  = prev_ff;
      if (req_fire) begin
         unique case (held_eff)
            pft_pkg::HELD_NONE: begin
               if (closing) begin
                  held_in = pft_pkg::HELD_NONE;
               end else begin
                  held_in  = pft_pkg::HELD_ONE;
                  first_in = cur;
               end
            end
            pft_pkg::HELD_ONE: begin
               if (closing) begin
                  held_in = pft_pkg::HELD_NONE;
               end else begin
                  held_in = pft_pkg::HELD_TWO;
                  prev_in = cur;
               end
            end
            default: begin
               if (closing) begin
                  held_in = pft_pkg::HELD_NONE;
               end else begin
                  held_in = pft_pkg::HELD_TWO;
                  prev_in = cur;
               end
            end
         endcase
      end
   end

   always_comb begin
      buf_valid_in = buf_valid_ff;
      slot_in      = slot_ff;
      priority if (req_fire && emit) begin
         buf_valid_in = 1'b1;
         slot_in      = pft_pkg::SLOT_A;
      end else if (rsp_fire) begin
         unique case (slot_ff)
            pft_pkg::SLOT_A: slot_in = pft_pkg::SLOT_B;
            pft_pkg::SLOT_B: slot_in = pft_pkg::SLOT_C;
            default: begin
               slot_in      = pft_pkg::SLOT_A;
               buf_valid_in = 1'b0;
            end
         endcase
      end else begin
         buf_valid_in = buf_valid_ff;
         slot_in      = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         winding_ff   <= 1'b0;
         counter_ff   <= '0;
         held_ff      <= pft_pkg::HELD_NONE;
         slot_ff      <= pft_pkg::SLOT_A;
         buf_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            winding_ff <= csr_write_data;
         end
         if (req_fire) begin
            counter_ff <= counter_eff + pft_pkg::INDEX_BITS'(1);
         end
         held_ff      <= held_in;
         slot_ff      <= slot_in;
         buf_valid_ff <= buf_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      prev_ff  <= prev_in;
      if (req_fire && emit) begin
         buf_ff[0] <= winding_ff ? first_ff : prev_ff;
         buf_ff[1] <= winding_ff ? prev_ff : first_ff;
         buf_ff[2] <= cur;
      end
   end

   always_comb begin
      unique case (slot_ff)
         pft_pkg::SLOT_A: begin
            rsp_bus.corner_ordinal = buf_ff[0].corner_ordinal;
            rsp_bus.point_index    = buf_ff[0].point_index;
         end
         pft_pkg::SLOT_B: begin
            rsp_bus.corner_ordinal = buf_ff[1].corner_ordinal;
            rsp_bus.point_index    = buf_ff[1].point_index;
         end
         default: begin
            rsp_bus.corner_ordinal = buf_ff[2].corner_ordinal;
            rsp_bus.point_index    = buf_ff[2].point_index;
         end
      endcase
   end

   assign rsp_bus.valid        = buf_valid_ff;
   assign rsp_bus.triangle_end = (slot_ff == pft_pkg::SLOT_C);

   `PFT_ASSERT_NOW(a_stall_while_busy, clock, reset, buf_valid_ff && !last_taken, !req_bus.ready)
   `PFT_ASSERT_NEXT(a_emit_loads_buffer, clock, reset, req_fire && emit, rsp_bus.valid && slot_ff == pft_pkg::SLOT_A)
   `PFT_ASSERT_NEXT(a_close_clears_held, clock, reset, req_fire && closing, held_ff == pft_pkg::HELD_NONE)
   `PFT_ASSERT_NEXT(a_start_restarts_count, clock, reset, req_fire && req_bus.mesh_start, counter_ff == pft_pkg::INDEX_BITS'(1))

endmodule

[verif/tb_polygon_fan_triangulator.sv]
// Testbench for the polygon fan triangulator: directed corner table, then random polygons.
// Expected vertices come from typed table rows or an in-bench fan model; checked in order.
// Depends on pft_pkg, pft_req_if, pft_rsp_if and the polygon_fan_triangulator RTL.
`timescale 1ns / 100ps

module tb_polygon_fan_triangulator;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_LIMIT   = 500;
   localparam int PHASE_ITEMS   = 90;
   localparam int DIRECTED_ROWS = 23;

   typedef struct packed {
      logic [pft_pkg::FIELD_BITS-1:0] corner_ordinal;
      logic [pft_pkg::FIELD_BITS-1:0] point_index;
      logic                           triangle_end;
   } corner_result;

   typedef struct packed {
      logic signed [pft_pkg::RAW_BITS-1:0] vertex_index;
      logic                                mesh_start;
      logic                                winding;
      logic                                typed;
      logic                                emits;
      logic [pft_pkg::FIELD_BITS-1:0]      a_ord;
      logic [pft_pkg::FIELD_BITS-1:0]      a_pt;
      logic [pft_pkg::FIELD_BITS-1:0]      b_ord;
      logic [pft_pkg::FIELD_BITS-1:0]      b_pt;
      logic [pft_pkg::FIELD_BITS-1:0]      c_ord;
      logic [pft_pkg::FIELD_BITS-1:0]      c_pt;
   } stim_row;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   pft_req_if req_bus ();
   pft_rsp_if rsp_bus ();

   polygon_fan_triangulator dut (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Fan model state.
   logic [pft_pkg::INDEX_BITS-1:0] next_ordinal = '0;
   pft_pkg::vertex_type            fan_first    = '0;
   pft_pkg::vertex_type            fan_previous = '0;
   pft_pkg::held_type              corners_held = pft_pkg::HELD_NONE;
   bit                             winding_cw   = 1'b0;

   corner_result expected_vertices [$];
   stim_row      current_row = '0;
   int           error_count = 0;
   int           quiet_cycles = 0;
   int           items_sent = 0;
   bit           sender_burst = 1'b0;
   bit           receiver_burst = 1'b0;

   stim_row directed_rows [DIRECTED_ROWS] = '{
      '{5,         1, 0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{7,         0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{9,         0, 0, 1, 1, 1, 7, 0, 5, 2, 9},
      '{-12,       0, 0, 1, 1, 2, 9, 0, 5, 3, 11},
      '{-1,        0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{16777215,  0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{-16777216, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{0,         0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{16777215,  0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{-16777216, 0, 0, 1, 1, 8, 24'hFFFFFF, 7, 0, 9, 24'hFFFFFF},
      '{3,         0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{4,         0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{20,        1, 0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{21,        0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{-23,       1, 0, 1, 0, 0, 0, 0, 0, 0, 0},
      '{30,        0, 1, 1, 0, 0, 0, 0, 0, 0, 0},
      '{31,        0, 1, 1, 0, 0, 0, 0, 0, 0, 0},
      '{-33,       0, 1, 1, 1, 1, 30, 2, 31, 3, 32},
      '{100,       0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{200,       0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{300,       0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-16777216, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0},
      '{16777215,  1, 1, 0, 0, 0, 0, 0, 0, 0, 0}
   };

   task automatic report_mismatch(input string what,
                                  input logic [pft_pkg::FIELD_BITS-1:0] got,
                                  input logic [pft_pkg::FIELD_BITS-1:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic fan_predict(input logic [pft_pkg::RAW_BITS-1:0] raw, input logic start,
                              output int produced, output corner_result [2:0] triangle);
      logic                  closing;
      pft_pkg::vertex_type   corner;
      closing = raw[pft_pkg::RAW_BITS-1];
      if (start) begin
         next_ordinal = '0;
         corners_held = pft_pkg::HELD_NONE;
      end
      corner.corner_ordinal = next_ordinal[pft_pkg::FIELD_BITS-1:0];
      corner.point_index = closing ? ~raw[pft_pkg::FIELD_BITS-1:0]
                                   : raw[pft_pkg::FIELD_BITS-1:0];
      next_ordinal = next_ordinal + pft_pkg::INDEX_BITS'(1);
      produced = 0;
      triangle = '0;
      case (corners_held)
         pft_pkg::HELD_NONE: begin
            if (!closing) begin
               fan_first = corner;
               corners_held = pft_pkg::HELD_ONE;
            end
         end
         pft_pkg::HELD_ONE: begin
            if (closing) begin
               corners_held = pft_pkg::HELD_NONE;
            end else begin
               fan_previous = corner;
               corners_held = pft_pkg::HELD_TWO;
            end
         end
         default: begin
            if (winding_cw) begin
               triangle[0] = {fan_first, 1'b0};
               triangle[1] = {fan_previous, 1'b0};
            end else begin
               triangle[0] = {fan_previous, 1'b0};
               triangle[1] = {fan_first, 1'b0};
            end
            triangle[2] = {corner, 1'b1};
            produced = 3;
            if (closing) begin
               corners_held = pft_pkg::HELD_NONE;
            end else begin
               fan_previous = corner;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : transfer_monitor
      corner_result [2:0] triangle;
      corner_result       want;
      int                 produced;
      if (!reset && req_bus.valid && req_bus.ready) begin
         fan_predict(req_bus.vertex_index, req_bus.mesh_start, produced, triangle);
         if (current_row.typed) begin
            produced = current_row.emits ? 3 : 0;
            triangle[0] = {current_row.a_ord, current_row.a_pt, 1'b0};
            triangle[1] = {current_row.b_ord, current_row.b_pt, 1'b0};
            triangle[2] = {current_row.c_ord, current_row.c_pt, 1'b1};
         end
         for (int k = 0; k < produced; k++) begin
            expected_vertices = {expected_vertices, triangle[k]};
         end
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_vertices.size() == 0) begin
            report_mismatch("vertex with none expected", rsp_bus.corner_ordinal, '0);
         end else begin
            want = expected_vertices.pop_front();
            if (rsp_bus.corner_ordinal !== want.corner_ordinal) begin
               report_mismatch("corner_ordinal", rsp_bus.corner_ordinal, want.corner_ordinal);
            end
            if (rsp_bus.point_index !== want.point_index) begin
               report_mismatch("point_index", rsp_bus.point_index, want.point_index);
            end
            if (rsp_bus.triangle_end !== want.triangle_end) begin
               report_mismatch("triangle_end", pft_pkg::FIELD_BITS'(rsp_bus.triangle_end),
                               pft_pkg::FIELD_BITS'(want.triangle_end));
            end
         end
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[polygon_fan_triangulator] ERROR");
         $finish;
      end
   end

   initial begin : result_sink
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 24) == 0) begin
            receiver_burst = !receiver_burst;
         end
         stall = receiver_burst ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   function automatic stim_row plain_row(input logic [pft_pkg::RAW_BITS-1:0] raw,
                                         input logic start);
      stim_row row;
      row = '0;
      row.vertex_index = raw;
      row.mesh_start = start;
      return row;
   endfunction

   function automatic logic [pft_pkg::RAW_BITS-1:0] random_corner(input bit closing);
      logic [pft_pkg::FIELD_BITS-1:0] point;
      point = pft_pkg::FIELD_BITS'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         point = pft_pkg::FIELD_BITS'($urandom_range(0, 15));
      end
      return closing ? {1'b1, ~point} : {1'b0, point};
   endfunction

   task automatic send_corner(input stim_row row);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 12);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      current_row = row;
      req_bus.valid <= 1'b1;
      req_bus.vertex_index <= row.vertex_index;
      req_bus.mesh_start <= row.mesh_start;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_vertices.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_winding(input bit cw);
      settle_block();
      csr_write_enable <= 1'b1;
      csr_write_data <= cw;
      winding_cw = cw;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      int shape;
      int corners;
      bit force_start;
      bit start;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.vertex_index = '0;
      req_bus.mesh_start = 1'b0;
      force_start = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      write_winding(1'b0);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].winding != winding_cw) begin
            write_winding(directed_rows[i].winding);
         end
         send_corner(directed_rows[i]);
      end

      for (int phase = 0; phase < 4; phase++) begin
         write_winding(phase % 2 == 0);
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) begin
            shape = $urandom_range(0, 15);
            if ($urandom_range(0, 5) == 0) begin
               sender_burst = !sender_burst;
            end
            if ($urandom_range(0, 30) == 0) begin
               settle_block();
            end
            if (shape == 0) begin
               send_corner(plain_row(pft_pkg::RAW_BITS'($urandom),
                                     $urandom_range(0, 3) == 0));
            end else begin
               corners = (shape == 1) ? $urandom_range(1, 2) : $urandom_range(3, 9);
               for (int k = 0; k < corners; k++) begin
                  start = (k == 0) && (force_start || $urandom_range(0, 7) == 0);
                  send_corner(plain_row(random_corner(k == corners - 1 && shape != 2),
                                        start));
               end
               // An open polygon is abandoned by a mesh start on the next one.
               force_start = (shape == 2);
            end
         end
      end

      settle_block();
      repeat (2 * SETTLE_CYCLES) @(negedge clock);
      if (expected_vertices.size() != 0) begin
         report_mismatch("vertices never seen",
                         pft_pkg::FIELD_BITS'(expected_vertices.size()), '0);
      end
      if (error_count == 0) begin
         $display("[polygon_fan_triangulator] OK");
      end else begin
         $display("[polygon_fan_triangulator] ERROR");
      end
      $finish;
   end

endmodule
